[src/dht11rx_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and constants for the dht11 frame receiver
// no dependencies
package dht11rx_pkg;

  localparam int DATA_BITS   = 32;
  localparam int FRAME_BITS  = 40;
  localparam int TIMER_W     = 16;
  localparam int SKIP_W      = 4;
  localparam int EDGE_CNT_W  = 5;
  localparam int BIT_CNT_W   = 6;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIMER_W-1:0]    THRESHOLD_RESET = TIMER_W'(100);
  localparam logic [SKIP_W-1:0]     SKIP_RESET      = SKIP_W'(3);
  localparam logic [EDGE_CNT_W-1:0] EDGE_CNT_MAX    = '1;

  // input item kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKIP      = 1'b1;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_EDGE   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               line_level;
    logic [TIMER_W-1:0] timer_count;
  } q_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    humidity;
    logic [BYTE_W-1:0]    humidity_fraction;
    logic [BYTE_W-1:0]    temperature;
    logic [BYTE_W-1:0]    temperature_fraction;
    logic                 checksum_ok;
    logic                 frame_nonzero;
    logic [BIT_CNT_W-1:0] bits_received;
  } result_t;

endpackage

[src/dht11rx_front.sv]
`timescale 1ns / 1ps
// front stage: takes input transfers, decodes the kind and drops unknown codes
// depends on dht11rx_pkg
module dht11rx_front
  import dht11rx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic               in_line_level,
  input  logic [TIMER_W-1:0] in_timer_count,
  input  logic               q_full,
  output logic               q_push,
  output q_entry_t           q_entry
);

  logic     valid_r, valid_nxt;
  q_entry_t entry_r, entry_nxt;
  logic     known;
  op_t      op_dec;
  logic     take;

  always_comb begin
    known  = 1'b1;
    op_dec = OP_START;
    case (in_kind)
      KIND_START:  op_dec = OP_START;
      KIND_EDGE:   op_dec = OP_EDGE;
      KIND_FINISH: op_dec = OP_FINISH;
      default:     known  = 1'b0;
    endcase
  end

  assign q_push   = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r && !q_push;
    entry_nxt = entry_r;
    if (take) begin
      valid_nxt = known;
      entry_nxt = '{op: op_dec, line_level: in_line_level, timer_count: in_timer_count};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q_entry = entry_r;

endmodule

[src/dht11rx_queue.sv]
`timescale 1ns / 1ps
// short register queue between the front and back stages
// depends on dht11rx_pkg
module dht11rx_queue
  import dht11rx_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t             slot_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[src/dht11rx_back.sv]
`timescale 1ns / 1ps
// back stage: frame state, bit decoding, finish check and result register
// depends on dht11rx_pkg
module dht11rx_back
  import dht11rx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TIMER_W-1:0] threshold,
  input  logic [SKIP_W-1:0]  edges_to_skip,
  input  logic               head_valid,
  input  q_entry_t           head_entry,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output result_t            res
);

  logic [EDGE_CNT_W-1:0] edge_count_r, edge_count_nxt;
  logic [TIMER_W-1:0]    high_start_r, high_start_nxt;
  logic [BIT_CNT_W-1:0]  bit_count_r, bit_count_nxt;
  logic [DATA_BITS-1:0]  data_word_r, data_word_nxt;
  logic [BYTE_W-1:0]     cksum_r, cksum_nxt;
  logic [BYTE_W-1:0]     hum_r, hum_nxt;
  logic [BYTE_W-1:0]     hum_frac_r, hum_frac_nxt;
  logic [BYTE_W-1:0]     temp_r, temp_nxt;
  logic [BYTE_W-1:0]     temp_frac_r, temp_frac_nxt;
  logic [BYTE_W-1:0]     saved_hum_r, saved_hum_nxt;
  logic [BYTE_W-1:0]     saved_temp_r, saved_temp_nxt;
  logic                  res_valid_r, res_valid_nxt;
  result_t               res_r, res_nxt;

  logic                  out_free;
  logic [TIMER_W-1:0]    high_time;
  logic                  bit_val;
  logic [BYTE_W-1:0]     b3, b2, b1, b0, byte_sum;
  logic                  nonzero, sum_ok;

  assign out_free = !res_valid_r || !res_stall;
  assign pop      = head_valid && (head_entry.op != OP_FINISH || out_free);

  assign high_time = head_entry.timer_count - high_start_r;
  assign bit_val   = (high_time > threshold);

  assign b3       = data_word_r[DATA_BITS-1 -: BYTE_W];
  assign b2       = data_word_r[DATA_BITS-1-BYTE_W -: BYTE_W];
  assign b1       = data_word_r[DATA_BITS-1-2*BYTE_W -: BYTE_W];
  assign b0       = data_word_r[BYTE_W-1:0];
  assign byte_sum = b3 + b2 + b1 + b0;
  assign nonzero  = (data_word_r != '0);
  assign sum_ok   = (byte_sum == cksum_r);

  always_comb begin
    edge_count_nxt = edge_count_r;
    high_start_nxt = high_start_r;
    bit_count_nxt  = bit_count_r;
    data_word_nxt  = data_word_r;
    cksum_nxt      = cksum_r;
    hum_nxt        = hum_r;
    hum_frac_nxt   = hum_frac_r;
    temp_nxt       = temp_r;
    temp_frac_nxt  = temp_frac_r;
    saved_hum_nxt  = saved_hum_r;
    saved_temp_nxt = saved_temp_r;
    res_valid_nxt  = res_valid_r && res_stall;
    res_nxt        = res_r;

    if (pop) begin
      case (head_entry.op)
        OP_START: begin
          saved_hum_nxt  = hum_r;
          saved_temp_nxt = temp_r;
          edge_count_nxt = '0;
          high_start_nxt = '0;
          bit_count_nxt  = '0;
          data_word_nxt  = '0;
          cksum_nxt      = '0;
        end
        OP_EDGE: begin
          if (edge_count_r >= EDGE_CNT_W'(edges_to_skip)) begin
            if (head_entry.line_level) begin
              high_start_nxt = head_entry.timer_count;
            end else begin
              if (bit_count_r < BIT_CNT_W'(DATA_BITS)) begin
                data_word_nxt = {data_word_r[DATA_BITS-2:0], bit_val};
              end else if (bit_count_r < BIT_CNT_W'(FRAME_BITS)) begin
                cksum_nxt = {cksum_r[BYTE_W-2:0], bit_val};
              end
              if (bit_count_r < BIT_CNT_W'(FRAME_BITS)) begin
                bit_count_nxt = bit_count_r + 1'b1;
              end
            end
          end
          if (edge_count_r != EDGE_CNT_MAX) begin
            edge_count_nxt = edge_count_r + 1'b1;
          end
        end
        OP_FINISH: begin
          if (nonzero) begin
            hum_frac_nxt  = b2;
            temp_frac_nxt = b0;
            // a bad checksum restores only the integer bytes
            hum_nxt       = sum_ok ? b3 : saved_hum_r;
            temp_nxt      = sum_ok ? b1 : saved_temp_r;
          end
          res_valid_nxt = 1'b1;
          res_nxt = '{
            humidity:             hum_nxt,
            humidity_fraction:    hum_frac_nxt,
            temperature:          temp_nxt,
            temperature_fraction: temp_frac_nxt,
            checksum_ok:          nonzero && sum_ok,
            frame_nonzero:        nonzero,
            bits_received:        bit_count_r
          };
        end
        default: begin
          res_nxt = res_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      high_start_r <= '0;
      bit_count_r  <= '0;
      data_word_r  <= '0;
      cksum_r      <= '0;
      hum_r        <= '0;
      hum_frac_r   <= '0;
      temp_r       <= '0;
      temp_frac_r  <= '0;
      saved_hum_r  <= '0;
      saved_temp_r <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      edge_count_r <= edge_count_nxt;
      high_start_r <= high_start_nxt;
      bit_count_r  <= bit_count_nxt;
      data_word_r  <= data_word_nxt;
      cksum_r      <= cksum_nxt;
      hum_r        <= hum_nxt;
      hum_frac_r   <= hum_frac_nxt;
      temp_r       <= temp_nxt;
      temp_frac_r  <= temp_frac_nxt;
      saved_hum_r  <= saved_hum_nxt;
      saved_temp_r <= saved_temp_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[src/dht11_frame_receiver_core.sv]
`timescale 1ns / 1ps
// dht11 frame receiver top level: configuration registers, front, queue, back
// depends on dht11rx_pkg, dht11rx_front, dht11rx_queue, dht11rx_back
//
// usage
//   input channel (in_valid / in_stall): one item per transfer; kind selects
//   start, line edge or finish; an unknown kind is taken and dropped
//   result channel (out_valid / out_stall): one result per finish item only
//   configuration port: cfg_we writes cfg_data to register cfg_index
//   (0 high-time threshold, 1 edges to skip); write only while idle
// timing
//   a finish result passes the front register, a queue slot and then the
//   result register before it shows on out_valid; one item per cycle while
//   out_stall does not back up the queue, as the back stage updates its
//   frame state for each item that it pops
// reset
//   rst_n is synchronous; clears frame state, held readings, the queue and
//   the result valid flag, and loads the threshold 100 and skip count 3
// stall
//   a stalled result holds; start and edge items keep flowing through the
//   back stage, and a finish waits at the queue head until the result
//   register frees, while behind it the queue and then in_stall back up
module dht11_frame_receiver_core
  import dht11rx_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic                   in_line_level,
  input  logic [TIMER_W-1:0]     in_timer_count,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [BYTE_W-1:0]      out_humidity,
  output logic [BYTE_W-1:0]      out_humidity_fraction,
  output logic [BYTE_W-1:0]      out_temperature,
  output logic [BYTE_W-1:0]      out_temperature_fraction,
  output logic                   out_checksum_ok,
  output logic                   out_frame_nonzero,
  output logic [BIT_CNT_W-1:0]   out_bits_received
);

  // configuration registers
  logic [TIMER_W-1:0] threshold_r, threshold_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;

  always_comb begin
    threshold_nxt = threshold_r;
    skip_nxt      = skip_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_nxt = cfg_data[TIMER_W-1:0];
        CFG_SKIP:      skip_nxt      = cfg_data[SKIP_W-1:0];
        default:       threshold_nxt = threshold_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      skip_r      <= SKIP_RESET;
    end else begin
      threshold_r <= threshold_nxt;
      skip_r      <= skip_nxt;
    end
  end

  // front to queue
  logic     q_push, q_full;
  q_entry_t q_push_entry;
  // queue to back
  logic     q_pop, q_head_valid;
  q_entry_t q_head_entry;
  result_t  res;

  dht11rx_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_line_level  (in_line_level),
    .in_timer_count (in_timer_count),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_push_entry)
  );

  dht11rx_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  dht11rx_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .threshold     (threshold_r),
    .edges_to_skip (skip_r),
    .head_valid    (q_head_valid),
    .head_entry    (q_head_entry),
    .pop           (q_pop),
    .res_valid     (out_valid),
    .res_stall     (out_stall),
    .res           (res)
  );

  // result fields out to their own ports
  assign out_humidity             = res.humidity;
  assign out_humidity_fraction    = res.humidity_fraction;
  assign out_temperature          = res.temperature;
  assign out_temperature_fraction = res.temperature_fraction;
  assign out_checksum_ok          = res.checksum_ok;
  assign out_frame_nonzero        = res.frame_nonzero;
  assign out_bits_received        = res.bits_received;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for dht11_frame_receiver_core: timed edge frames in, readings out
// depends on dht11rx_pkg and the receiver rtl; carries its own frame decoder for checking
module tb;
  import dht11rx_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;

  typedef struct {
    logic [1:0]         kind;
    logic               level;
    logic [TIMER_W-1:0] stamp;
  } line_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = '0;
  logic               in_line_level = 1'b0;
  logic [TIMER_W-1:0] in_timer_count = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_humidity;
  logic [BYTE_W-1:0]    out_humidity_fraction;
  logic [BYTE_W-1:0]    out_temperature;
  logic [BYTE_W-1:0]    out_temperature_fraction;
  logic                 out_checksum_ok;
  logic                 out_frame_nonzero;
  logic [BIT_CNT_W-1:0] out_bits_received;

  dht11_frame_receiver_core DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_kind                  (in_kind),
    .in_line_level            (in_line_level),
    .in_timer_count           (in_timer_count),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_humidity             (out_humidity),
    .out_humidity_fraction    (out_humidity_fraction),
    .out_temperature          (out_temperature),
    .out_temperature_fraction (out_temperature_fraction),
    .out_checksum_ok          (out_checksum_ok),
    .out_frame_nonzero        (out_frame_nonzero),
    .out_bits_received        (out_bits_received)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder copy of the block state
  logic [TIMER_W-1:0]    thr_q = THRESHOLD_RESET;
  logic [SKIP_W-1:0]     skip_q = SKIP_RESET;
  logic [EDGE_CNT_W-1:0] edge_cnt = '0;
  logic [TIMER_W-1:0]    rise_time = '0;
  logic [BIT_CNT_W-1:0]  bit_cnt = '0;
  logic [DATA_BITS-1:0]  word = '0;
  logic [BYTE_W-1:0]     csum = '0;
  logic [BYTE_W-1:0]     hum = '0, hum_frac = '0, temp = '0, temp_frac = '0;
  logic [BYTE_W-1:0]     hum_saved = '0, temp_saved = '0;

  line_item_t pending_items[$];
  result_t    expected_readings[$];
  line_item_t in_flight;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int queued_items = 0;
  int queued_finishes = 0;
  int items_taken = 0;
  int readings_checked = 0;
  int good_sums = 0;
  int zero_frames = 0;
  int backpressure_cycles = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // works out what one accepted transfer does to the frame state
  task automatic decode_transfer(input line_item_t it);
    logic [TIMER_W-1:0] high;
    logic               one;
    logic [BYTE_W-1:0]  sum;
    result_t            r;
    case (it.kind)
      KIND_START: begin
        hum_saved  = hum;
        temp_saved = temp;
        edge_cnt   = '0;
        rise_time  = '0;
        bit_cnt    = '0;
        word       = '0;
        csum       = '0;
      end
      KIND_EDGE: begin
        if (edge_cnt >= skip_q) begin
          if (it.level) begin
            rise_time = it.stamp;
          end else begin
            high = it.stamp - rise_time;   // wraps with the timer
            one  = high > thr_q;
            if (bit_cnt < DATA_BITS) word = {word[DATA_BITS-2:0], one};
            else if (bit_cnt < FRAME_BITS) csum = {csum[BYTE_W-2:0], one};
            if (bit_cnt < FRAME_BITS) bit_cnt++;
          end
        end
        if (edge_cnt != EDGE_CNT_MAX) edge_cnt++;
      end
      KIND_FINISH: begin
        r = '0;
        if (word != '0) begin
          r.frame_nonzero = 1'b1;
          hum       = word[31:24];
          hum_frac  = word[23:16];
          temp      = word[15:8];
          temp_frac = word[7:0];
          sum = hum + hum_frac + temp + temp_frac;
          if (sum == csum) begin
            r.checksum_ok = 1'b1;
          end else begin
            // integer parts roll back, fractions stay
            hum  = hum_saved;
            temp = temp_saved;
          end
        end
        r.humidity             = hum;
        r.humidity_fraction    = hum_frac;
        r.temperature          = temp;
        r.temperature_fraction = temp_frac;
        r.bits_received        = bit_cnt;
        expected_readings.push_back(r);
      end
      default: ;
    endcase
  endtask

  // sender: one item per transfer, random gap bursts between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_transfer(in_flight);
        items_taken++;
      end
      if (in_valid && in_stall) backpressure_cycles++;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(99, 0) < send_idle_pct) begin
          send_gap = $urandom_range(13, 0);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_flight = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_kind        <= in_flight.kind;
          in_line_level  <= in_flight.level;
          in_timer_count <= in_flight.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: compares readings in order, stalls in bursts or one long hold
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: reading with none expected, expected nothing, actual hum %0d temp %0d",
                   $time, out_humidity, out_temperature);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (want.checksum_ok) good_sums++;
          if (!want.frame_nonzero) zero_frames++;
          check_field("humidity", want.humidity, out_humidity);
          check_field("humidity_fraction", want.humidity_fraction, out_humidity_fraction);
          check_field("temperature", want.temperature, out_temperature);
          check_field("temperature_fraction", want.temperature_fraction,
                      out_temperature_fraction);
          check_field("checksum_ok", want.checksum_ok, out_checksum_ok);
          check_field("frame_nonzero", want.frame_nonzero, out_frame_nonzero);
          check_field("bits_received", want.bits_received, out_bits_received);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (holds_started != hold_requests) begin
        holds_started++;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
        stall_left = $urandom_range(13, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic level, input logic [15:0] stamp);
    line_item_t it;
    it.kind  = kind;
    it.level = level;
    it.stamp = stamp;
    pending_items.push_back(it);
    queued_items++;
    if (kind == KIND_FINISH) queued_finishes++;
  endtask

  // high time close to the threshold that decodes as the wanted bit (always a zero at threshold 16'hFFFF)
  function automatic logic [15:0] high_ticks(input logic one);
    int unsigned lo, hi;
    if (one && thr_q != 16'hFFFF) begin
      lo = thr_q + 1;
      hi = (thr_q > 65535 - 150) ? 65535 : thr_q + 150;
    end else begin
      hi = thr_q;
      lo = (thr_q < 150) ? 0 : thr_q - 150;
    end
    return 16'($urandom_range(hi, lo));
  endfunction

  // start, response edges, nbits of low/high pulses, finish
  task automatic push_frame(input logic [31:0] data, input logic [7:0] sum, input int nbits);
    logic [39:0] bits;
    logic [15:0] stamp;
    logic        one;
    int          i;
    bits  = {data, sum};
    stamp = 16'($urandom);
    push_item(KIND_START, 1'($urandom), 16'($urandom));
    for (i = 0; i < skip_q; i++) begin
      stamp = stamp + 16'($urandom_range(90, 20));
      push_item(KIND_EDGE, i[0], stamp);
    end
    for (i = 0; i < nbits; i++) begin
      one   = (i < FRAME_BITS) ? bits[39 - i] : 1'($urandom);
      stamp = stamp + 16'($urandom_range(60, 10));
      push_item(KIND_EDGE, 1'b1, stamp);
      stamp = stamp + high_ticks(one);
      push_item(KIND_EDGE, 1'b0, stamp);
    end
    push_item(KIND_FINISH, 1'($urandom), 16'($urandom));
  endtask

  task automatic push_episode();
    int          pick;
    logic [31:0] data;
    logic [7:0]  sum;
    pick = $urandom_range(99, 0);
    data = ($urandom_range(19, 0) == 0) ? 32'd0 : 32'($urandom);
    sum  = data[31:24] + data[23:16] + data[15:8] + data[7:0];
    if ($urandom_range(3, 0) == 0) sum = sum + 8'($urandom_range(255, 1));
    if (pick < 35) begin
      push_frame(data, sum, ($urandom_range(9, 0) == 0) ? $urandom_range(48, 41) : 40);
    end else if (pick < 70) begin
      push_frame(data, sum, $urandom_range(39, 0));
    end else if (pick < 80) begin
      // finish again with no new start
      push_item(KIND_FINISH, 1'($urandom), 16'($urandom));
    end else begin
      repeat ($urandom_range(12, 1)) push_item(2'($urandom), 1'($urandom), 16'($urandom));
      if ($urandom_range(1, 0) == 1) push_item(KIND_FINISH, 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) thr_q = val;
    else skip_q = val[SKIP_W-1:0];
  endtask

  // all items taken, all readings back, then let trailing edges drain
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    int first_item;
    int first_finish;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edges before any start, wrapped high time, threshold boundary,
    // unknown kind, finish without start, repeated finish, empty frame
    send_idle_pct = 25;
    recv_idle_pct = 25;
    push_item(KIND_EDGE, 1'b0, 16'h0000);
    push_item(KIND_EDGE, 1'b1, 16'hFFFF);
    push_item(KIND_UNKNOWN, 1'b1, 16'hFFFF);
    push_item(KIND_EDGE, 1'b0, 16'h1234);
    push_item(KIND_EDGE, 1'b1, 16'hFFF0);
    push_item(KIND_EDGE, 1'b0, 16'h0080);
    push_item(KIND_FINISH, 1'b0, 16'h0000);
    push_item(KIND_FINISH, 1'b1, 16'hFFFF);
    push_item(KIND_START, 1'b1, 16'hFFFF);
    push_item(KIND_FINISH, 1'b0, 16'h0000);
    push_item(KIND_EDGE, 1'b0, 16'h0000);
    push_item(KIND_EDGE, 1'b1, 16'h0000);
    push_item(KIND_EDGE, 1'b0, 16'h0000);
    push_item(KIND_EDGE, 1'b1, 16'h0000);
    push_item(KIND_EDGE, 1'b0, 16'h0064);
    push_item(KIND_EDGE, 1'b1, 16'h0100);
    push_item(KIND_EDGE, 1'b0, 16'h0165);
    push_item(KIND_EDGE, 1'b0, 16'h0200);
    push_item(KIND_FINISH, 1'b1, 16'h5555);
    settle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 15;
        end
        1: begin
          write_reg(CFG_THRESHOLD, 16'h0000);
          write_reg(CFG_SKIP, 16'h0000);
          send_idle_pct = 10;
          recv_idle_pct = 10;
        end
        2: begin
          write_reg(CFG_THRESHOLD, 16'hFFFF);
          write_reg(CFG_SKIP, 16'h000F);
          send_idle_pct = 10;
          recv_idle_pct = 30;
        end
        3: begin
          write_reg(CFG_THRESHOLD, 16'($urandom));
          write_reg(CFG_SKIP, 16'($urandom));
          send_idle_pct = 30;
          recv_idle_pct = 10;
        end
        4: begin
          write_reg(CFG_THRESHOLD, 16'($urandom_range(400, 1)));
          write_reg(CFG_SKIP, 16'd1);
          send_idle_pct = 40;
          recv_idle_pct = 40;
        end
        default: begin
          write_reg(CFG_THRESHOLD, 16'd250);
          write_reg(CFG_SKIP, 16'd4);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      @(negedge clk);
      if (phase == 1) begin
        // long receiver hold with short frames queued so the block backs up
        hold_requests++;
        repeat (8) push_frame(32'($urandom) | 32'd1, 8'($urandom), 2);
      end
      first_item   = queued_items;
      first_finish = queued_finishes;
      while (queued_items - first_item < 250 || queued_finishes - first_finish < 5)
        push_episode();
      settle();
    end

    $display("%0d items taken, %0d readings checked (%0d checksum good, %0d zero frames)",
             items_taken, readings_checked, good_sums, zero_frames);
    $display("six register settings, %0d cycles of input back-pressure seen",
             backpressure_cycles);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
src/dht11rx_pkg.sv
src/dht11rx_front.sv
src/dht11rx_queue.sv
src/dht11rx_back.sv
src/dht11_frame_receiver_core.sv
test/tb.sv
